// File: design/keeloq_decrypt_learn_verify_top_defines.svh
// Assertion macros for the KeeLoq learn-and-verify block.
// Define NO_ASSERTIONS to compile them out.
`ifndef KEELOQ_DECRYPT_LEARN_VERIFY_TOP_DEFINES_SVH
`define KEELOQ_DECRYPT_LEARN_VERIFY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define KLQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KLQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define KLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: design/klq_pkg.sv
package klq_pkg;

    // Non-linear function table, indexed by five state bits
    localparam logic [31:0] KLQ_NLF      = 32'h3A5C742E;
    localparam int          KLQ_ROUNDS   = 528;
    localparam int          RND_W        = 10;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(KLQ_ROUNDS - 1);
    localparam logic [31:0] KLQ_PFX_LO   = 32'h20000000;
    localparam logic [31:0] KLQ_PFX_HI   = 32'h60000000;
    localparam logic [5:0]  KEY_IDX_START = 6'd15;

    // Learning kinds
    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_NORMAL = 2'd1,
        KIND_XOR    = 2'd2,
        KIND_SERIAL = 2'd3
    } kind_t;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LO   = 5'b00010,
        ST_HI   = 5'b00100,
        ST_DEC  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    // One decrypt round of the NLFSR: shift left, feed back into bit 0
    function automatic logic [31:0] klq_round(input logic [31:0] x, input logic kb);
        logic [4:0] sel;
        logic       fb;
        sel = {x[30], x[25], x[19], x[8], x[0]};
        fb  = x[31] ^ x[15] ^ kb ^ KLQ_NLF[sel];
        return {x[30:0], fb};
    endfunction

endpackage

// File: design/keeloq_decrypt_learn_verify_top.sv
// Channel  Dir  tdata (low bit up)                      tuser
// s_*      in   hop_word[31:0] fix_word[63:32]           kind[1:0]
//               seed[127:64]
// m_*      out  button[3:0] counter[19:4], zero pad      matched[0]
//
// One shared NLFSR round unit, one round per cycle, 528 rounds per decrypt.
// Simple, xor and serial kinds: accept, one decrypt, finish.
// Normal kind: two key-derivation decrypts first, then the decrypt, then finish.
// s_tready is high only while the sequencer is idle; a finished result sits
// in the output register while the next frame is taken.
// Reset (rst_n, async, active low) clears the sequencer and output valid.
`include "keeloq_decrypt_learn_verify_top_defines.svh"

module keeloq_decrypt_learn_verify_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // hop_word[31:0], fix_word[63:32], seed[127:64]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // button[3:0], counter[19:4], zero[23:20]
    output logic [0:0]   m_tuser    // matched[0]
);

    klq_pkg::state_t              state_reg, state_next;
    logic [klq_pkg::RND_W-1:0]    rnd_reg, rnd_next;
    logic [31:0]                  x_reg, x_next;
    logic [63:0]                  key_reg, key_next;
    logic [31:0]                  lo_reg, lo_next;
    logic [31:0]                  hop_reg, hop_next;
    logic [31:0]                  fix_reg, fix_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         matched_reg, matched_next;
    logic [3:0]                   button_reg, button_next;
    logic [15:0]                  counter_reg, counter_next;

    logic                         s_xfer;
    logic                         m_xfer;
    logic [31:0]                  in_hop;
    logic [31:0]                  in_fix;
    logic [63:0]                  in_seed;
    logic [27:0]                  in_serial;
    logic [7:0]                   byte_sum;
    logic [63:0]                  derived_key;
    logic [5:0]                   key_idx;
    logic [31:0]                  x_round;
    logic                         last_rnd;
    logic                         busy_rnd;
    logic                         out_free;
    logic                         p_match;

    assign s_tready = (state_reg == klq_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_valid_reg && m_tready;

    assign in_hop    = s_tdata[31:0];
    assign in_fix    = s_tdata[63:32];
    assign in_seed   = s_tdata[127:64];
    assign in_serial = in_fix[27:0];
    assign byte_sum  = in_serial[7:0] + in_serial[15:8];

    // Key for the kinds that need no key-derivation decrypt
    always_comb
    begin
        case (klq_pkg::kind_t'(s_tuser))
            klq_pkg::KIND_XOR:
                derived_key = {4'b0, in_serial, 4'b0, in_serial} ^ in_seed;
            klq_pkg::KIND_SERIAL:
                derived_key = {in_serial[23:0], byte_sum, in_seed[31:0]};
            default:
                derived_key = in_seed;
        endcase
    end

    // Shared round unit
    assign key_idx  = klq_pkg::KEY_IDX_START - rnd_reg[5:0];
    assign x_round  = klq_pkg::klq_round(x_reg, key_reg[key_idx]);
    assign last_rnd = (rnd_reg == klq_pkg::RND_LAST);
    assign busy_rnd = (state_reg == klq_pkg::ST_LO) || (state_reg == klq_pkg::ST_HI) ||
                      (state_reg == klq_pkg::ST_DEC);

    assign out_free = !m_valid_reg || m_tready;
    assign p_match  = (x_reg[31:28] == fix_reg[31:28]) && (x_reg[23:16] == fix_reg[7:0]);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        x_next       = x_reg;
        key_next     = key_reg;
        lo_next      = lo_reg;
        hop_next     = hop_reg;
        fix_next     = fix_reg;
        m_valid_next = m_valid_reg;
        matched_next = matched_reg;
        button_next  = button_reg;
        counter_next = counter_reg;

        // Drop valid once the result transfer completes
        if (m_xfer)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            klq_pkg::ST_IDLE:
            begin
                if (s_xfer)
                begin
                    hop_next = in_hop;
                    fix_next = in_fix;
                    rnd_next = '0;
                    if (klq_pkg::kind_t'(s_tuser) == klq_pkg::KIND_NORMAL)
                    begin
                        key_next   = in_seed;
                        x_next     = {4'b0, in_serial} | klq_pkg::KLQ_PFX_LO;
                        state_next = klq_pkg::ST_LO;
                    end
                    else
                    begin
                        key_next   = derived_key;
                        x_next     = in_hop;
                        state_next = klq_pkg::ST_DEC;
                    end
                end
            end
            klq_pkg::ST_LO:
            begin
                rnd_next = rnd_reg + 1'b1;
                x_next   = x_round;
                if (last_rnd)
                begin
                    lo_next    = x_round;
                    x_next     = {4'b0, fix_reg[27:0]} | klq_pkg::KLQ_PFX_HI;
                    rnd_next   = '0;
                    state_next = klq_pkg::ST_HI;
                end
            end
            klq_pkg::ST_HI:
            begin
                rnd_next = rnd_reg + 1'b1;
                x_next   = x_round;
                if (last_rnd)
                begin
                    key_next   = {x_round, lo_reg};
                    x_next     = hop_reg;
                    rnd_next   = '0;
                    state_next = klq_pkg::ST_DEC;
                end
            end
            klq_pkg::ST_DEC:
            begin
                rnd_next = rnd_reg + 1'b1;
                x_next   = x_round;
                if (last_rnd)
                begin
                    rnd_next   = '0;
                    state_next = klq_pkg::ST_FIN;
                end
            end
            klq_pkg::ST_FIN:
            begin
                // Hold the plaintext until the output register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    matched_next = p_match;
                    button_next  = p_match ? x_reg[31:28] : fix_reg[31:28];
                    counter_next = p_match ? x_reg[15:0] : 16'd0;
                    state_next   = klq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = klq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= klq_pkg::ST_IDLE;
            rnd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        key_reg     <= key_next;
        lo_reg      <= lo_next;
        hop_reg     <= hop_next;
        fix_reg     <= fix_next;
        matched_reg <= matched_next;
        button_reg  <= button_next;
        counter_reg <= counter_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {4'b0, counter_reg, button_reg};
    assign m_tuser[0] = matched_reg;

    // Checks
    `KLQ_ASSERT_NOW(a_rnd_range, clk, rst_n, 1'b1, rnd_reg <= klq_pkg::RND_LAST,
        "round counter beyond last round")
    `KLQ_ASSERT_NEXT(a_rnd_step, clk, rst_n, busy_rnd && !last_rnd,
        rnd_reg == $past(rnd_reg) + 1'b1, "round counter did not advance")
    `KLQ_ASSERT_NEXT(a_normal_start, clk, rst_n,
        s_xfer && (s_tuser == klq_pkg::KIND_NORMAL), state_reg == klq_pkg::ST_LO,
        "normal kind did not start key derivation")
    `KLQ_ASSERT_NEXT(a_fin_load, clk, rst_n, (state_reg == klq_pkg::ST_FIN) && out_free,
        m_valid_reg && (state_reg == klq_pkg::ST_IDLE), "finished result not loaded")
    `KLQ_ASSERT_NOW(a_miss_cnt, clk, rst_n, m_valid_reg && !matched_reg,
        counter_reg == 16'd0, "counter nonzero on mismatch")

endmodule
